// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the unescaper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, switched off while reset is held
`define JSU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define JSU_ASSERT(lbl, clk, rstn, prop, msg)
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/jsu_pkg.sv -----
// shared types, constants and utf-8 helpers for the string unescaper
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] TAIL_NONE  = 2'd0;
  localparam logic [1:0] TAIL_BYTE  = 2'd1;
  localparam logic [1:0] TAIL_CLOSE = 2'd2;
  localparam logic [1:0] TAIL_ERR   = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CONTROL = 2'd1;
  localparam logic [1:0] ERR_ESCAPE  = 2'd2;
  localparam logic [1:0] ERR_HEX     = 2'd3;

  localparam logic [20:0] CP_REPLACE = 21'h00fffd;

  // work for one input item: up to two code points, then at most one tail result
  typedef struct packed {
    logic        cpa_v;
    logic [20:0] cpa;
    logic        cpb_v;
    logic [20:0] cpb;
    logic [1:0]  tail;
    logic [7:0]  tail_byte;
    logic [1:0]  tail_err;
  } job_t;

  // index of the final utf-8 byte of a code point
  function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
    logic [1:0] r;
    if (cp >= 21'h010000) r = 2'd3;
    else if (cp >= 21'h000800) r = 2'd2;
    else if (cp >= 21'h000080) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [7:0] r;
    if (cp >= 21'h010000) begin
      case (idx)
        2'd0:    r = {5'b11110, cp[20:18]};
        2'd1:    r = {2'b10, cp[17:12]};
        2'd2:    r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[5:0]};
      endcase
    end else if (cp >= 21'h000800) begin
      case (idx)
        2'd0:    r = {4'b1110, cp[15:12]};
        2'd1:    r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[5:0]};
      endcase
    end else if (cp >= 21'h000080) begin
      case (idx)
        2'd0:    r = {3'b110, cp[10:6]};
        default: r = {2'b10, cp[5:0]};
      endcase
    end else begin
      r = cp[7:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/jsu_front.sv -----
// front end: escape state machine, turns each item into a job for the queue
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  localparam logic [2:0] MODE_PLAIN      = 3'd0;
  localparam logic [2:0] MODE_ESC        = 3'd1;
  localparam logic [2:0] MODE_HEX        = 3'd2;
  localparam logic [2:0] MODE_AFTER_HIGH = 3'd3;
  localparam logic [2:0] MODE_ESC2       = 3'd4;
  localparam logic [2:0] MODE_HEX2       = 3'd5;

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] high_r, high_nxt;

  logic        accept;
  job_t        job;
  logic [8:0]  esc;
  logic [4:0]  hexd;
  logic [15:0] acc_new;
  logic [26:0] join_sum;

  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    logic [4:0] r;
    t = 8'd0;
    if (b inside {[8'h30:8'h39]}) begin
      t = b - 8'h30;
      r = {1'b0, t[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      t = b - 8'h57;
      r = {1'b0, t[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      t = b - 8'h37;
      r = {1'b0, t[3:0]};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign esc      = simple_escape(in_byte);
  assign hexd     = hex_value(in_byte);
  assign acc_new  = {acc_r[11:0], hexd[3:0]};
  assign join_sum = {1'b0, high_r, 10'b0} + {11'b0, acc_new} - 27'h35fdc00;

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    high_nxt = high_r;
    job      = '0;
    case (mode_r)
      MODE_ESC, MODE_ESC2: begin
        if (esc[8]) begin
          job.cpa_v     = (mode_r == MODE_ESC2);
          job.cpa       = CP_REPLACE;
          job.tail      = TAIL_BYTE;
          job.tail_byte = esc[7:0];
          mode_nxt      = MODE_PLAIN;
          acc_nxt       = '0;
          cnt_nxt       = '0;
          high_nxt      = '0;
        end else if (in_byte == 8'h75) begin
          mode_nxt = (mode_r == MODE_ESC) ? MODE_HEX : MODE_HEX2;
          acc_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          job.tail     = TAIL_ERR;
          job.tail_err = ERR_ESCAPE;
          mode_nxt     = MODE_PLAIN;
          acc_nxt      = '0;
          cnt_nxt      = '0;
          high_nxt     = '0;
        end
      end
      MODE_HEX, MODE_HEX2: begin
        if (hexd[4]) begin
          job.tail     = TAIL_ERR;
          job.tail_err = ERR_HEX;
          mode_nxt     = MODE_PLAIN;
          acc_nxt      = '0;
          cnt_nxt      = '0;
          high_nxt     = '0;
        end else if (cnt_r != 2'd3) begin
          acc_nxt = acc_new;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (mode_r == MODE_HEX && acc_new inside {[16'hd800:16'hdbff]}) begin
            high_nxt = acc_new;
            mode_nxt = MODE_AFTER_HIGH;
          end else begin
            mode_nxt  = MODE_PLAIN;
            high_nxt  = '0;
            job.cpa_v = 1'b1;
            if (mode_r == MODE_HEX) begin
              job.cpa = (acc_new inside {[16'hdc00:16'hdfff]}) ? CP_REPLACE
                                                                 : {5'b0, acc_new};
            end else if (acc_new inside {[16'hdc00:16'hdfff]}) begin
              job.cpa = join_sum[20:0];
            end else begin
              job.cpa   = CP_REPLACE;
              job.cpb_v = 1'b1;
              job.cpb   = {5'b0, acc_new};
            end
          end
        end
      end
      default: begin
        // plain mode, and the character after a lone high surrogate
        if (mode_r == MODE_AFTER_HIGH) begin
          job.cpa_v = (in_byte != 8'h5c);
          job.cpa   = CP_REPLACE;
        end
        high_nxt = '0;
        if (mode_r == MODE_AFTER_HIGH && in_byte == 8'h5c) begin
          mode_nxt = MODE_ESC2;
          high_nxt = high_r;
        end else if (in_byte == 8'h22) begin
          job.tail = TAIL_CLOSE;
          mode_nxt = MODE_PLAIN;
          acc_nxt  = '0;
          cnt_nxt  = '0;
        end else if (in_byte == 8'h5c) begin
          mode_nxt = MODE_ESC;
        end else if (in_byte < 8'h20 || in_byte == 8'h7f) begin
          job.tail     = TAIL_ERR;
          job.tail_err = ERR_CONTROL;
          mode_nxt     = MODE_PLAIN;
          acc_nxt      = '0;
          cnt_nxt      = '0;
        end else begin
          job.tail      = TAIL_BYTE;
          job.tail_byte = in_byte;
          mode_nxt      = MODE_PLAIN;
        end
      end
    endcase
  end

  assign push     = accept && (job.cpa_v || job.cpb_v || job.tail != TAIL_NONE);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
      cnt_r  <= '0;
      high_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

// ----- hw/rtl/jsu_queue.sv -----
// short job queue between front end and back end
`include "assert_macros.svh"

module jsu_queue
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `JSU_ASSERT(a_no_push_full, clk, rst_n, push |-> !full, "push into full queue")
  `JSU_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> head_valid, "pop from empty queue")
  `JSU_ASSERT(a_count_up, clk, rst_n, (push && !pop) |=> count_r == $past(count_r) + 1'b1, "queue count lost a push")
  `JSU_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !head_valid, "queue not empty after reset")

endmodule

// ----- hw/rtl/jsu_back.sv -----
// back end: expands jobs into utf-8 result items through an output register
`include "assert_macros.svh"

module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_closed,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  localparam logic [1:0] PART_A = 2'd0;
  localparam logic [1:0] PART_B = 2'd1;
  localparam logic [1:0] PART_T = 2'd2;

  logic [1:0]  part_r, part_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  logic        has_r, closed_r, last_r;
  logic [1:0]  err_r;

  logic [1:0]  cur_part;
  logic [20:0] cur_cp;
  logic [1:0]  cur_last_idx;
  logic        item_last;
  logic        load_ok, emit;
  logic [7:0]  item_byte;
  logic        item_has, item_closed;
  logic [1:0]  item_err;

  always_comb begin
    if (part_r == PART_A && head.cpa_v) cur_part = PART_A;
    else if ((part_r == PART_A || part_r == PART_B) && head.cpb_v) cur_part = PART_B;
    else cur_part = PART_T;
  end

  assign cur_cp       = (cur_part == PART_A) ? head.cpa : head.cpb;
  assign cur_last_idx = utf8_last_idx(cur_cp);

  always_comb begin
    case (cur_part)
      PART_A:  item_last = (idx_r == cur_last_idx) && !head.cpb_v && head.tail == TAIL_NONE;
      PART_B:  item_last = (idx_r == cur_last_idx) && head.tail == TAIL_NONE;
      default: item_last = 1'b1;
    endcase
  end

  always_comb begin
    item_byte   = '0;
    item_has    = 1'b0;
    item_closed = 1'b0;
    item_err    = ERR_NONE;
    if (cur_part != PART_T) begin
      item_byte = utf8_byte(cur_cp, idx_r);
      item_has  = 1'b1;
    end else begin
      case (head.tail)
        TAIL_BYTE: begin
          item_byte = head.tail_byte;
          item_has  = 1'b1;
        end
        TAIL_CLOSE: item_closed = 1'b1;
        TAIL_ERR:   item_err    = head.tail_err;
        default:    item_has    = 1'b0;
      endcase
    end
  end

  assign load_ok = !out_valid_r || !out_stall;
  assign emit    = head_valid && load_ok;
  assign pop     = emit && item_last;

  always_comb begin
    part_nxt = part_r;
    idx_nxt  = idx_r;
    if (emit) begin
      if (item_last) begin
        part_nxt = PART_A;
        idx_nxt  = '0;
      end else if (idx_r == cur_last_idx) begin
        part_nxt = cur_part + 2'd1;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (emit) out_valid_nxt = 1'b1;
    else out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r      <= PART_A;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      part_r      <= part_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r   <= item_byte;
      has_r    <= item_has;
      closed_r <= item_closed;
      err_r    <= item_err;
      last_r   <= item_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_has_byte   = has_r;
  assign out_closed     = closed_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

  `JSU_ASSERT(a_pop_on_last, clk, rst_n, pop |-> (emit && item_last), "job left before its last item")
  `JSU_ASSERT(a_tail_present, clk, rst_n, (emit && cur_part == PART_T) |-> head.tail != TAIL_NONE, "empty tail emitted")
  `JSU_ASSERT(a_idx_in_range, clk, rst_n, (head_valid && cur_part != PART_T) |-> idx_r <= cur_last_idx, "utf-8 byte index out of range")

endmodule

// ----- hw/rtl/json_string_unescape_utf8_core.sv -----
// json string body unescaper producing utf-8 bytes, one input byte per cycle
// each item's results go via the job queue, then the output register, to out_valid
// throughput: one input byte per cycle while the job queue has room; the back end
// sends one result per cycle while out_stall is low, working through each job in turn
// the four-entry job queue absorbs bursts of up to six results from one byte
// reset: synchronous active-low rst_n clears decode state, queue and output valid
module json_string_unescape_utf8_core
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_closed,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  logic push, pop, q_full, head_valid;
  job_t push_job, head;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_closed     (out_closed),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule

// ----- verif/json_string_unescape_utf8_core_tb.sv -----
// self-checking testbench for the json string unescaper with utf-8 output
module json_string_unescape_utf8_core_tb;
  import jsu_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 40;
  localparam int PHASE_BYTES  = 32;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_DEL       = 8'h7f;

  typedef enum logic [2:0] {
    MD_PLAIN, MD_ESC, MD_HEX, MD_AFTER_HIGH, MD_ESC2, MD_HEX2
  } dec_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       closed;
    logic [1:0] err;
    logic       last;
  } out_item_t;

  class unescape_scoreboard;
    out_item_t pending_q[$];
    out_item_t burst_q[$];
    dec_mode_t mode;
    logic [15:0] acc;
    logic [1:0] ndig;
    logic [15:0] high_cu;
    logic high_held;
    int failures;
    int n_bytes;
    int n_results;
    int n_closes;
    int n_errors;

    function new();
      reset_state();
      failures = 0;
      n_bytes = 0;
      n_results = 0;
      n_closes = 0;
      n_errors = 0;
    endfunction

    function void reset_state();
      mode = MD_PLAIN;
      acc = '0;
      ndig = '0;
      high_cu = '0;
      high_held = 1'b0;
    endfunction

    function void emit(logic [7:0] b, logic has, logic cl, logic [1:0] e);
      out_item_t r;
      r.data = b;
      r.has = has;
      r.closed = cl;
      r.err = e;
      r.last = 1'b0;
      burst_q.push_back(r);
    endfunction

    function void emit_cp(logic [31:0] cp);
      if (cp >= 32'h10000) begin
        emit({5'b11110, cp[20:18]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[17:12]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end else if (cp >= 32'h800) begin
        emit({4'b1110, cp[15:12]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end else if (cp >= 32'h80) begin
        emit({3'b110, cp[10:6]}, 1'b1, 1'b0, ERR_NONE);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end else begin
        emit(cp[7:0], 1'b1, 1'b0, ERR_NONE);
      end
    endfunction

    function void raise(logic [1:0] code);
      reset_state();
      emit(8'h00, 1'b0, 1'b0, code);
    endfunction

    function void plain_char(logic [7:0] b);
      mode = MD_PLAIN;
      if (b == CH_QUOTE) begin
        reset_state();
        emit(8'h00, 1'b0, 1'b1, ERR_NONE);
      end else if (b == CH_BACKSLASH) begin
        mode = MD_ESC;
      end else if (b < 8'h20 || b == CH_DEL) begin
        raise(ERR_CONTROL);
      end else begin
        emit(b, 1'b1, 1'b0, ERR_NONE);
      end
    endfunction

    // character of a simple escape letter, zero when it is not one
    function logic [7:0] escape_char(logic [7:0] b);
      logic [7:0] c;
      case (b)
        CH_QUOTE:     c = CH_QUOTE;
        CH_BACKSLASH: c = CH_BACKSLASH;
        CH_SLASH:     c = CH_SLASH;
        8'h62:        c = 8'h08;
        8'h66:        c = 8'h0c;
        8'h6e:        c = 8'h0a;
        8'h72:        c = 8'h0d;
        8'h74:        c = 8'h09;
        default:      c = 8'h00;
      endcase
      return c;
    endfunction

    // bit 4 set when b is not a hex digit
    function logic [4:0] hex_digit(logic [7:0] b);
      logic [4:0] d;
      if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
      else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h61 + 8'd10);
      else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h41 + 8'd10);
      else d = 5'd16;
      return d;
    endfunction

    function void note_input(logic [7:0] b);
      logic [7:0] c;
      logic [4:0] d;
      logic [15:0] v;
      logic [31:0] cp;
      out_item_t tail;
      n_bytes++;
      burst_q.delete();
      case (mode)
        MD_ESC, MD_ESC2: begin
          c = escape_char(b);
          if (c != 8'h00) begin
            if (mode == MD_ESC2) emit_cp({11'h0, CP_REPLACE});
            reset_state();
            emit(c, 1'b1, 1'b0, ERR_NONE);
          end else if (b == CH_U) begin
            mode = (mode == MD_ESC) ? MD_HEX : MD_HEX2;
            acc = '0;
            ndig = '0;
          end else begin
            raise(ERR_ESCAPE);
          end
        end
        MD_HEX, MD_HEX2: begin
          d = hex_digit(b);
          if (d[4]) begin
            raise(ERR_HEX);
          end else begin
            acc = {acc[11:0], d[3:0]};
            if (ndig < 2'd3) begin
              ndig = ndig + 2'd1;
            end else begin
              v = acc;
              acc = '0;
              ndig = '0;
              if (mode == MD_HEX) begin
                if (v >= 16'hd800 && v <= 16'hdbff) begin
                  high_cu = v;
                  high_held = 1'b1;
                  mode = MD_AFTER_HIGH;
                end else begin
                  if (v >= 16'hdc00 && v <= 16'hdfff) v = CP_REPLACE[15:0];
                  emit_cp({16'h0, v});
                  reset_state();
                end
              end else begin
                if (v >= 16'hdc00 && v <= 16'hdfff) begin
                  cp = (({16'h0, high_cu} << 10) + {16'h0, v}) - 32'h35fdc00;
                  emit_cp(cp);
                end else begin
                  emit_cp({11'h0, CP_REPLACE});
                  emit_cp({16'h0, v});
                end
                reset_state();
              end
            end
          end
        end
        MD_AFTER_HIGH: begin
          if (b == CH_BACKSLASH) begin
            mode = MD_ESC2;
          end else begin
            emit_cp({11'h0, CP_REPLACE});
            high_cu = '0;
            high_held = 1'b0;
            plain_char(b);
          end
        end
        default: plain_char(b);
      endcase
      if (burst_q.size() > 0) begin
        tail = burst_q.pop_back();
        tail.last = 1'b1;
        burst_q.push_back(tail);
      end
      foreach (burst_q[i]) pending_q.push_back(burst_q[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (got.closed === 1'b1) n_closes++;
      if (got.err !== ERR_NONE) n_errors++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: out_byte %02h has_byte %0b closed %0b error_code %0d",
               got.data, got.has, got.closed, got.err);
        failures++;
        return;
      end
      want = pending_q.pop_front();
      if (got.data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, got.data);
        failures++;
      end
      if (got.has !== want.has) begin
        $error("out_has_byte: expected %0b, got %0b", want.has, got.has);
        failures++;
      end
      if (got.closed !== want.closed) begin
        $error("out_closed: expected %0b, got %0b", want.closed, got.closed);
        failures++;
      end
      if (got.err !== want.err) begin
        $error("out_error_code: expected %0d, got %0d", want.err, got.err);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_closed;
  logic [1:0] out_error_code;
  logic       out_last;

  unescape_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int cycles;
  logic [7:0] frag_q[$];

  json_string_unescape_utf8_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_closed     (out_closed),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver: random stall, plus a long hold-off when asked
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_byte, out_has_byte, out_closed, out_error_code, out_last});
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
    @(negedge clk);
  endtask

  task automatic send_frag();
    while (frag_q.size() > 0) send_byte(frag_q.pop_front());
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + 8'(d);
    else if ($urandom_range(0, 1)) c = 8'h61 + 8'(d) - 8'd10;
    else c = 8'h41 + 8'(d) - 8'd10;
    return c;
  endfunction

  function automatic void add_u(input logic [15:0] v);
    frag_q.push_back(CH_BACKSLASH);
    frag_q.push_back(CH_U);
    frag_q.push_back(hex_char(v[15:12]));
    frag_q.push_back(hex_char(v[11:8]));
    frag_q.push_back(hex_char(v[7:4]));
    frag_q.push_back(hex_char(v[3:0]));
  endfunction

  function automatic logic [7:0] printable();
    logic [7:0] b;
    b = 8'($urandom_range(8'h20, 8'h7e));
    if (b == CH_QUOTE || b == CH_BACKSLASH) b = 8'h61;
    return b;
  endfunction

  function automatic logic [7:0] simple_letter();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = CH_QUOTE;
      1: b = CH_BACKSLASH;
      2: b = CH_SLASH;
      3: b = 8'h62;
      4: b = 8'h66;
      5: b = 8'h6e;
      6: b = 8'h72;
      default: b = 8'h74;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bad_letter();
    logic [7:0] b;
    do b = 8'($urandom); while (sb.escape_char(b) != 8'h00 || b == CH_U);
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    logic [4:0] d;
    do begin
      b = 8'($urandom);
      d = sb.hex_digit(b);
    end while (!d[4]);
    return b;
  endfunction

  function automatic logic [15:0] high_unit();
    return 16'($urandom_range(16'hd800, 16'hdbff));
  endfunction

  function automatic logic [15:0] low_unit();
    return 16'($urandom_range(16'hdc00, 16'hdfff));
  endfunction

  task automatic random_fragment();
    int kind;
    int n;
    logic [15:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 14) begin
      frag_q.push_back(printable());
    end else if (kind < 24) begin
      frag_q.push_back(8'($urandom_range(8'h80, 8'hff)));
    end else if (kind < 36) begin
      frag_q.push_back(CH_BACKSLASH);
      frag_q.push_back(simple_letter());
    end else if (kind < 50) begin
      case ($urandom_range(0, 3))
        0: v = 16'($urandom_range(0, 16'h7f));
        1: v = 16'($urandom_range(16'h80, 16'h7ff));
        2: v = 16'($urandom);
        default: v = low_unit();
      endcase
      add_u(v);
    end else if (kind < 60) begin
      add_u(high_unit());
      add_u(low_unit());
    end else if (kind < 66) begin
      add_u(high_unit());
      case ($urandom_range(0, 3))
        0: frag_q.push_back(printable());
        1: frag_q.push_back(CH_QUOTE);
        2: frag_q.push_back(8'($urandom_range(0, 8'h1f)));
        default: frag_q.push_back(8'($urandom_range(8'h80, 8'hff)));
      endcase
    end else if (kind < 70) begin
      add_u(high_unit());
      frag_q.push_back(CH_BACKSLASH);
      frag_q.push_back(simple_letter());
    end else if (kind < 74) begin
      add_u(high_unit());
      case ($urandom_range(0, 2))
        0: v = 16'($urandom_range(0, 16'hd7ff));
        1: v = 16'($urandom_range(16'he000, 16'hffff));
        default: v = high_unit();
      endcase
      add_u(v);
    end else if (kind < 80) begin
      frag_q.push_back(CH_QUOTE);
    end else if (kind < 86) begin
      frag_q.push_back(8'($urandom));
    end else if (kind < 90) begin
      frag_q.push_back(CH_BACKSLASH);
      frag_q.push_back(bad_letter());
    end else if (kind < 94) begin
      frag_q.push_back(CH_BACKSLASH);
      frag_q.push_back(CH_U);
      n = $urandom_range(0, 3);
      repeat (n) frag_q.push_back(hex_char(4'($urandom)));
      frag_q.push_back(non_hex());
    end else if (kind < 97) begin
      add_u(high_unit());
      frag_q.push_back(CH_BACKSLASH);
      if ($urandom_range(0, 1)) begin
        frag_q.push_back(bad_letter());
      end else begin
        frag_q.push_back(CH_U);
        frag_q.push_back(hex_char(4'($urandom)));
        frag_q.push_back(non_hex());
      end
    end else begin
      frag_q.push_back($urandom_range(0, 1) ? CH_DEL : 8'($urandom_range(0, 8'h1f)));
    end
    send_frag();
  endtask

  task automatic random_phase(input int s_pct, input int r_pct);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = sb.n_bytes + PHASE_BYTES;
    while (sb.n_bytes < target) random_fragment();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // control bytes, raw byte, close, tab, bad letter, two-byte and four-byte
    // code points, non-hex digit
    frag_q = '{8'h00, CH_DEL, 8'hff, 8'h41, CH_QUOTE,
               CH_BACKSLASH, 8'h74, CH_BACKSLASH, 8'h71,
               CH_BACKSLASH, CH_U, 8'h30, 8'h30, 8'h65, 8'h39,
               CH_BACKSLASH, CH_U, 8'h44, 8'h38, 8'h33, 8'h44,
               CH_BACKSLASH, CH_U, 8'h64, 8'h65, 8'h30, 8'h30,
               CH_BACKSLASH, CH_U, 8'h78};
    send_frag();
    drain();

    random_phase(23, 65);
    random_phase(65, 23);

    // receiver holds off while plain and raw bytes keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    repeat (20) begin
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(8'h80, 8'hff)));
      else send_byte(printable());
    end
    drain();

    random_phase(0, 0);

    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("run covered %0d input bytes giving %0d results (%0d closes, %0d errors)",
             sb.n_bytes, sb.n_results, sb.n_closes, sb.n_errors);
    $display("escapes, surrogate pairs and broken sequences under idle, stall and hold-off");
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8_core.sv
verif/json_string_unescape_utf8_core_tb.sv
